FILE: hdl/cgsag_pkg.sv
// Shared types, codes and sizes for the coarse-grid scatter-add/gather block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package cgsag_pkg;

   localparam int COARSE_DEPTH = 4096;
   localparam int ADDR_W = (COARSE_DEPTH > 1) ? $clog2(COARSE_DEPTH) : 1;
   localparam int IDX_W = 13;
   localparam int VAL_W = 32;
   localparam int STORE_W = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Function codes on req_func.
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ACC = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ = 2'd3;

   // Classified operations handed from front to back.
   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_ACC = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ = 3'd3;
   localparam logic [2:0] OP_SKIP = 3'd4;
   localparam logic [2:0] OP_RANGE = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_SAT = 2'd3;

   localparam logic [STORE_W-1:0] STORE_MAX = {1'b0, {(STORE_W-1){1'b1}}};
   localparam logic [STORE_W-1:0] STORE_MIN = {1'b1, {(STORE_W-1){1'b0}}};

   typedef struct packed {
      logic [2:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  value;
   } cmd_type;

endpackage

FILE: hdl/coarse_grid_scatter_add_gather.sv
// Coarse-grid scatter-add/gather store, top level.
// Uses cgsag_pkg and instantiates cgsag_front, cgsag_queue and cgsag_back.
//
// Usage:
//   A request beat (req_func, req_coarse_index, req_fine_value) is taken on
//   a rising edge with start high and busy low. Functions are clear,
//   accumulate (saturating), write and read. Each request gives exactly one
//   result beat on rsp_coarse_value / rsp_status, shown for one cycle with
//   rsp_valid high; results come out in request order.
//   With the queue empty, a request passes its queue entry, the execute
//   stage and the result register. Accumulate, write, read and the index
//   errors go at one per cycle outside a sweep, back-to-back accumulates
//   to one entry included, set by the single read-modify-write pass over
//   the store memory with forwarding. A clear sweeps the store one entry a
//   cycle over all COARSE_DEPTH (4096) entries, during which busy is high
//   and later requests wait. After reset the same sweep runs with busy high.
//   The receiver cannot stall; busy rises only when the four-entry
//   command queue is full or a sweep is running.
module coarse_grid_scatter_add_gather (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic signed [cgsag_pkg::IDX_W-1:0]  req_coarse_index,
   input  logic signed [cgsag_pkg::VAL_W-1:0]  req_fine_value,
   output logic                                rsp_valid,
   output logic signed [cgsag_pkg::STORE_W-1:0] rsp_coarse_value,
   output logic [1:0]                          rsp_status
);

   logic               push;
   logic               pop;
   logic               q_empty;
   logic               q_full;
   logic               sweeping;
   cgsag_pkg::cmd_type push_cmd;
   cgsag_pkg::cmd_type pop_cmd;

   cgsag_front u_front (
      .start            (start),
      .req_func         (req_func),
      .req_coarse_index (req_coarse_index),
      .req_fine_value   (req_fine_value),
      .q_full           (q_full),
      .sweeping         (sweeping),
      .busy             (busy),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   cgsag_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_empty  (q_empty),
      .q_full   (q_full)
   );

   cgsag_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .pop_cmd          (pop_cmd),
      .pop              (pop),
      .sweeping         (sweeping),
      .rsp_valid        (rsp_valid),
      .rsp_coarse_value (rsp_coarse_value),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: hdl/cgsag_front.sv
// Front end: takes request beats, classifies them and pushes commands.
// Depends on cgsag_pkg for the command type and the code constants.
module cgsag_front (
   input  logic                              start,
   input  logic [1:0]                        req_func,
   input  logic signed [cgsag_pkg::IDX_W-1:0] req_coarse_index,
   input  logic signed [cgsag_pkg::VAL_W-1:0] req_fine_value,
   input  logic                              q_full,
   input  logic                              sweeping,
   output logic                              busy,
   output logic                              push,
   output cgsag_pkg::cmd_type                push_cmd
);

   logic negative;
   logic out_of_range;

   assign busy = q_full | sweeping;
   assign push = start & ~busy;

   assign negative = req_coarse_index[cgsag_pkg::IDX_W-1];
   assign out_of_range = 32'(req_coarse_index[cgsag_pkg::IDX_W-2:0]) >=
                         32'(cgsag_pkg::COARSE_DEPTH);

   always_comb begin
      push_cmd.addr = cgsag_pkg::ADDR_W'(req_coarse_index[cgsag_pkg::IDX_W-2:0]);
      push_cmd.value = req_fine_value;
      unique case (req_func)
         cgsag_pkg::FUNC_CLEAR: push_cmd.op = cgsag_pkg::OP_CLEAR;
         cgsag_pkg::FUNC_ACC:   push_cmd.op = cgsag_pkg::OP_ACC;
         cgsag_pkg::FUNC_WRITE: push_cmd.op = cgsag_pkg::OP_WRITE;
         default:               push_cmd.op = cgsag_pkg::OP_READ;
      endcase
      // Clear ignores the index; all other functions check it first.
      if (req_func != cgsag_pkg::FUNC_CLEAR) begin
         if (negative) begin
            push_cmd.op = cgsag_pkg::OP_SKIP;
         end else if (out_of_range) begin
            push_cmd.op = cgsag_pkg::OP_RANGE;
         end
      end
   end

endmodule

FILE: hdl/cgsag_queue.sv
// Short command queue between the front end and the store back end.
// Depends on cgsag_pkg for the command type and the queue depth.
module cgsag_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cgsag_pkg::cmd_type push_cmd,
   input  logic               pop,
   output cgsag_pkg::cmd_type pop_cmd,
   output logic               q_empty,
   output logic               q_full
);

   cgsag_pkg::cmd_type                 entry_ff [cgsag_pkg::QUEUE_DEPTH];
   logic [cgsag_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cgsag_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cgsag_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign q_empty = (count_ff == '0);
   assign q_full = (count_ff == cgsag_pkg::QCNT_W'(cgsag_pkg::QUEUE_DEPTH));
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/cgsag_back.sv
// Back end: owns the coarse store memory, runs read-modify-write with
// forwarding and the clearing sweep, and registers the result beat.
// Depends on cgsag_pkg for the command type, codes and sizes.
module cgsag_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  cgsag_pkg::cmd_type                  pop_cmd,
   output logic                                pop,
   output logic                                sweeping,
   output logic                                rsp_valid,
   output logic signed [cgsag_pkg::STORE_W-1:0] rsp_coarse_value,
   output logic [1:0]                          rsp_status
);

   localparam int SW = cgsag_pkg::STORE_W;
   localparam int VW = cgsag_pkg::VAL_W;
   localparam int AW = cgsag_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(cgsag_pkg::COARSE_DEPTH - 1);

   logic [SW-1:0]      store [cgsag_pkg::COARSE_DEPTH];

   logic [SW-1:0]      rdata_ff;
   logic               exe_valid_ff;
   cgsag_pkg::cmd_type exe_cmd_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [SW-1:0]      fwd_data_ff;
   logic               sweep_ff, sweep_in;
   logic [AW-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic               rsp_valid_ff;
   logic [SW-1:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [SW-1:0]      old_value;
   logic [SW:0]        sum;
   logic [SW-1:0]      wdata;
   logic               exe_we;
   logic               saturated;

   assign sweeping = sweep_ff;
   // A clear in the execute stage holds off further pops until its sweep ends.
   assign pop = ~q_empty & ~sweep_ff &
                ~(exe_valid_ff & (exe_cmd_ff.op == cgsag_pkg::OP_CLEAR));

   assign old_value = fwd_hit_ff ? fwd_data_ff : rdata_ff;
   assign sum = {old_value[SW-1], old_value} +
                {{(SW+1-VW){exe_cmd_ff.value[VW-1]}}, exe_cmd_ff.value};
   assign saturated = (sum[SW] != sum[SW-1]);

   always_comb begin
      exe_we = 1'b0;
      wdata = {{(SW-VW){exe_cmd_ff.value[VW-1]}}, exe_cmd_ff.value};
      rsp_value_in = '0;
      rsp_status_in = cgsag_pkg::ST_DONE;
      case (exe_cmd_ff.op)
         cgsag_pkg::OP_ACC: begin
            exe_we = exe_valid_ff;
            if (saturated) begin
               wdata = sum[SW] ? cgsag_pkg::STORE_MIN : cgsag_pkg::STORE_MAX;
               rsp_status_in = cgsag_pkg::ST_SAT;
            end else begin
               wdata = sum[SW-1:0];
            end
         end
         cgsag_pkg::OP_WRITE: exe_we = exe_valid_ff;
         cgsag_pkg::OP_READ:  rsp_value_in = old_value;
         cgsag_pkg::OP_SKIP:  rsp_status_in = cgsag_pkg::ST_SKIP;
         cgsag_pkg::OP_RANGE: rsp_status_in = cgsag_pkg::ST_RANGE;
         default: ;
      endcase
   end

   // The memory read is registered, so a write to the same entry in the cycle
   // of the pop is carried along in the forwarding register.
   assign fwd_hit_in = pop & exe_we & (pop_cmd.addr == exe_cmd_ff.addr);

   always_comb begin
      sweep_in = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (exe_valid_ff && exe_cmd_ff.op == cgsag_pkg::OP_CLEAR) begin
         sweep_in = 1'b1;
         sweep_cnt_in = '0;
      end else if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == LAST_ADDR) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         sweep_ff <= 1'b1;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exe_valid_ff <= pop;
         sweep_ff <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= exe_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      exe_cmd_ff <= pop_cmd;
      fwd_hit_ff <= fwd_hit_in;
      fwd_data_ff <= wdata;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rdata_ff <= store[pop_cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         store[sweep_cnt_ff] <= '0;
      end else if (exe_we) begin
         store[exe_cmd_ff.addr] <= wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_coarse_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
